[hw/rtl/euler_to_quaternion_macros.svh]
// Assertion helpers used by the top level of this block.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2Q_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/e2q_pkg.sv]
`timescale 1ns / 1ps
package e2q_pkg;

    // Angle accumulator, CORDIC vector and trig word widths.
    localparam int ANG_W    = 44;
    localparam int VEC_W    = 42;
    localparam int TRIG_W   = 32;
    localparam int Q_W      = 32;
    localparam int W_W      = 31;
    localparam int ATAN_LEN = 40;

    // Queue between the front and the back.
    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    // Angle constants in Q.40.
    localparam logic signed [ANG_W-1:0] PI_Q40      = 44'sd3454217652358;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q40 = 44'sd1727108826179;

    // Start vector (0.5, 0) in Q.40, and unity in Q.30.
    localparam logic signed [VEC_W-1:0] VEC_INIT = 42'sd549755813888;
    localparam logic signed [Q_W-1:0]   ONE_Q30  = 32'sd1073741824;
    localparam logic [W_W-1:0]          ONE_W    = 31'd1073741824;

    // atan(2^-i) in Q.40.
    localparam logic signed [ANG_W-1:0] ATAN_ROM [ATAN_LEN] = '{
        44'sd863554413089, 44'sd509785937287, 44'sd269356888665, 44'sd136729762476,
        44'sd68630207382,  44'sd34348560106,  44'sd17178471287,  44'sd8589759836,
        44'sd4294945451,   44'sd2147480917,   44'sd1073741483,   44'sd536870869,
        44'sd268435451,    44'sd134217727,    44'sd67108864,     44'sd33554432,
        44'sd16777216,     44'sd8388608,      44'sd4194304,      44'sd2097152,
        44'sd1048576,      44'sd524288,       44'sd262144,       44'sd131072,
        44'sd65536,        44'sd32768,        44'sd16384,        44'sd8192,
        44'sd4096,         44'sd2048,         44'sd1024,         44'sd512,
        44'sd256,          44'sd128,          44'sd64,           44'sd32,
        44'sd16,           44'sd8,            44'sd4,            44'sd2
    };

    // A request after range reduction: three half angles and their flip flags.
    typedef struct packed {
        logic signed [ANG_W-1:0] ang_roll;
        logic signed [ANG_W-1:0] ang_pitch;
        logic signed [ANG_W-1:0] ang_yaw;
        logic                    flip_roll;
        logic                    flip_pitch;
        logic                    flip_yaw;
    } t_class;

    // Queue status seen by the front and the top level.
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_queue_stat;

    // Pipeline advance and entry valid for a CORDIC lane.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

[hw/rtl/e2q_front.sv]
`timescale 1ns / 1ps
module e2q_front
    import e2q_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic signed [31:0]   i_roll_angle,
    input  logic signed [31:0]   i_pitch_angle,
    input  logic signed [31:0]   i_yaw_angle,
    input  t_queue_stat          i_qstat,
    output logic                 o_qpush,
    output t_class               o_cls
);

    typedef struct packed {
        logic                    flip;
        logic signed [ANG_W-1:0] ang;
    } t_red;

    // Halve the angle into Q.40 and fold it into the CORDIC range.
    function automatic t_red reduce_angle(input logic signed [31:0] a);
        logic signed [ANG_W-1:0] v;
        t_red                    r;
        v = ANG_W'(a) <<< 11;
        r.flip = 1'b0;
        r.ang  = v;
        if (v > HALF_PI_Q40) begin
            r.flip = 1'b1;
            r.ang  = v - PI_Q40;
        end else if (v < -HALF_PI_Q40) begin
            r.flip = 1'b1;
            r.ang  = v + PI_Q40;
        end
        return r;
    endfunction

    logic   r_valid;
    t_class r_cls;
    t_class n_cls;
    t_red   w_roll;
    t_red   w_pitch;
    t_red   w_yaw;
    logic   w_load;

    // Classify the incoming request.
    always_comb begin
        w_roll           = reduce_angle(i_roll_angle);
        w_pitch          = reduce_angle(i_pitch_angle);
        w_yaw            = reduce_angle(i_yaw_angle);
        n_cls.ang_roll   = w_roll.ang;
        n_cls.ang_pitch  = w_pitch.ang;
        n_cls.ang_yaw    = w_yaw.ang;
        n_cls.flip_roll  = w_roll.flip;
        n_cls.flip_pitch = w_pitch.flip;
        n_cls.flip_yaw   = w_yaw.flip;
    end

    // The holding register empties into the queue whenever the queue has room.
    assign w_load  = !r_valid || !i_qstat.full;
    assign o_full  = r_valid && i_qstat.full;
    assign o_qpush = r_valid && !i_qstat.full;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_push) begin
            r_cls <= n_cls;
        end
    end

endmodule

[hw/rtl/e2q_queue.sv]
`timescale 1ns / 1ps
module e2q_queue
    import e2q_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_class      i_data,
    input  logic        i_pop,
    output t_class      o_data,
    output t_queue_stat o_stat
);

    t_class            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_data       = r_mem[r_rp];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.count = r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hw/rtl/e2q_cordic.sv]
`timescale 1ns / 1ps
module e2q_cordic
    import e2q_pkg::*;
#(
    parameter int STEPS = 30
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_stage_ctl               i_ctl,
    input  logic signed [ANG_W-1:0]  i_ang,
    input  logic                     i_flip,
    output logic                     o_valid,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);

    localparam int NSTEP = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
    localparam logic signed [VEC_W-1:0] RND = VEC_W'(512);

    logic signed [VEC_W-1:0] r_x [NSTEP+1];
    logic signed [VEC_W-1:0] r_y [NSTEP+1];
    logic signed [ANG_W-1:0] r_a [NSTEP];
    logic                    r_f [NSTEP+1];
    logic                    r_v [NSTEP+1];
    logic                    r_ov;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [VEC_W-1:0] w_xr;
    logic signed [VEC_W-1:0] w_yr;

    // Entry stage: start vector and reduced angle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0] <= VEC_INIT;
            r_y[0] <= '0;
            r_a[0] <= i_ang;
            r_f[0] <= i_flip;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_f[i+1] <= r_f[i];
                if (!r_a[i][ANG_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                end
            end
        end
        if (i < NSTEP - 1) begin : g_ang
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    if (!r_a[i][ANG_W-1]) begin
                        r_a[i+1] <= r_a[i] - ATAN_ROM[i];
                    end else begin
                        r_a[i+1] <= r_a[i] + ATAN_ROM[i];
                    end
                end
            end
        end
    end

    // Valid chain follows the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTEP; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
            for (int k = 0; k < NSTEP; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_ov <= r_v[NSTEP];
        end
    end

    // Round to Q.30 and undo the half-turn fold.
    assign w_xr = r_x[NSTEP] + RND;
    assign w_yr = r_y[NSTEP] + RND;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_cos <= r_f[NSTEP] ? -w_xr[VEC_W-1:10] : w_xr[VEC_W-1:10];
            r_sin <= r_f[NSTEP] ? -w_yr[VEC_W-1:10] : w_yr[VEC_W-1:10];
        end
    end

    assign o_valid = r_ov;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

[hw/rtl/e2q_back.sv]
`timescale 1ns / 1ps
module e2q_back
    import e2q_pkg::*;
#(
    parameter int STEPS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_class                i_cls,
    input  logic                  i_q_empty,
    output logic                  o_deq,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [W_W-1:0]        o_quat_w,
    output logic signed [Q_W-1:0] o_quat_x,
    output logic signed [Q_W-1:0] o_quat_y,
    output logic signed [Q_W-1:0] o_quat_z
);

    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = 31;
    localparam int REM_W      = 63;
    localparam logic signed [63:0] RND30 = 64'sd536870912;

    typedef struct packed {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
        t_quat       q;
    } t_sqrt;

    typedef struct packed {
        logic [3:0][REM_W-1:0] rem;
        logic [3:0][W_W-1:0]   quo;
        logic [3:0]            neg;
        logic [31:0]           n;
    } t_div;

    // Round a Q.60 product back to Q.30, half up.
    function automatic logic signed [Q_W-1:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + RND30;
        return t[61:30];
    endfunction

    logic w_en;
    t_stage_ctl w_ctl;
    logic w_v_r, w_v_p, w_v_y;
    logic signed [TRIG_W-1:0] w_cr, w_sr, w_cp, w_sp, w_cy, w_sy;

    logic r_p1v, r_p2v, r_p3v, r_p4v, r_p5v, r_p6v;
    logic signed [63:0] r_crcp_w, r_srsp_w, r_crsp_w, r_srcp_w;
    logic signed [TRIG_W-1:0] r_cy1, r_sy1, r_cy2, r_sy2;
    logic signed [Q_W-1:0] r_crcp, r_srsp, r_crsp, r_srcp;
    logic signed [63:0] r_m [8];
    t_quat r_q4, r_q5, r_q6;
    logic [61:0] r_sq [4];
    logic [62:0] r_s01, r_s23;

    t_sqrt r_sqt [SQ_STAGES+1];
    logic  r_sqv [SQ_STAGES+1];
    t_div  r_div [DIV_STAGES+1];
    logic  r_dv  [DIV_STAGES+1];

    logic                  r_out_valid;
    logic [W_W-1:0]        r_w;
    logic signed [Q_W-1:0] r_x, r_y, r_z;

    // Whole back end advances while the output register is free or being taken.
    assign w_en      = !r_out_valid || i_pop;
    assign o_deq     = w_en && !i_q_empty;
    assign w_ctl.en    = w_en;
    assign w_ctl.valid = o_deq;

    // Sine and cosine of the three half angles.
    e2q_cordic #(.STEPS(STEPS)) u_cordic_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_ang(i_cls.ang_roll), .i_flip(i_cls.flip_roll),
        .o_valid(w_v_r), .o_cos(w_cr), .o_sin(w_sr)
    );
    e2q_cordic #(.STEPS(STEPS)) u_cordic_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_ang(i_cls.ang_pitch), .i_flip(i_cls.flip_pitch),
        .o_valid(w_v_p), .o_cos(w_cp), .o_sin(w_sp)
    );
    e2q_cordic #(.STEPS(STEPS)) u_cordic_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_ang(i_cls.ang_yaw), .i_flip(i_cls.flip_yaw),
        .o_valid(w_v_y), .o_cos(w_cy), .o_sin(w_sy)
    );

    // Roll-pitch pair products, then rounding.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_crcp_w <= w_cr * w_cp;
            r_srsp_w <= w_sr * w_sp;
            r_crsp_w <= w_cr * w_sp;
            r_srcp_w <= w_sr * w_cp;
            r_cy1    <= w_cy;
            r_sy1    <= w_sy;
            r_crcp   <= rnd30(r_crcp_w);
            r_srsp   <= rnd30(r_srsp_w);
            r_crsp   <= rnd30(r_crsp_w);
            r_srcp   <= rnd30(r_srcp_w);
            r_cy2    <= r_cy1;
            r_sy2    <= r_sy1;
        end
    end

    // Products with yaw, then the four quaternion sums.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m[0] <= r_crcp * r_cy2;
            r_m[1] <= r_srsp * r_sy2;
            r_m[2] <= r_srcp * r_cy2;
            r_m[3] <= r_crsp * r_sy2;
            r_m[4] <= r_crsp * r_cy2;
            r_m[5] <= r_srcp * r_sy2;
            r_m[6] <= r_crcp * r_sy2;
            r_m[7] <= r_srsp * r_cy2;
            r_q4.w <= rnd30(r_m[0] + r_m[1]);
            r_q4.x <= rnd30(r_m[2] - r_m[3]);
            r_q4.y <= rnd30(r_m[4] + r_m[5]);
            r_q4.z <= rnd30(r_m[6] - r_m[7]);
        end
    end

    // Sum of squares over three stages.
    always_ff @(posedge i_clk) begin
        logic signed [63:0] p0, p1, p2, p3;
        if (w_en) begin
            p0 = r_q4.w * r_q4.w;
            p1 = r_q4.x * r_q4.x;
            p2 = r_q4.y * r_q4.y;
            p3 = r_q4.z * r_q4.z;
            r_sq[0] <= p0[61:0];
            r_sq[1] <= p1[61:0];
            r_sq[2] <= p2[61:0];
            r_sq[3] <= p3[61:0];
            r_q5    <= r_q4;
            r_s01   <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
            r_s23   <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
            r_q6    <= r_q5;
            r_sqt[0].v <= {1'b0, r_s01} + {1'b0, r_s23};
            r_sqt[0].r <= '0;
            r_sqt[0].q <= r_q6;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        always_ff @(posedge i_clk) begin
            logic [63:0] trial;
            if (w_en) begin
                trial = r_sqt[j].r + BIT;
                r_sqt[j+1].q <= r_sqt[j].q;
                if (r_sqt[j].v >= trial) begin
                    r_sqt[j+1].v <= r_sqt[j].v - trial;
                    r_sqt[j+1].r <= (r_sqt[j].r >> 1) + BIT;
                end else begin
                    r_sqt[j+1].v <= r_sqt[j].v;
                    r_sqt[j+1].r <= r_sqt[j].r >> 1;
                end
            end
        end
    end

    // Divider setup: magnitudes scaled by 2^30 plus half the norm.
    // The scalar part sits in the top slice of the packed quaternion, so lane 0 takes w.
    always_ff @(posedge i_clk) begin
        logic [31:0] n;
        logic [31:0] mag;
        logic [3:0][Q_W-1:0] qv;
        if (w_en) begin
            n  = r_sqt[SQ_STAGES].r[31:0];
            qv = r_sqt[SQ_STAGES].q;
            r_div[0].n <= n;
            for (int k = 0; k < 4; k++) begin
                mag = qv[3-k][Q_W-1] ? -qv[3-k] : qv[3-k];
                r_div[0].rem[k] <= (REM_W'(mag) << 30) + REM_W'(n >> 1);
                r_div[0].quo[k] <= '0;
                r_div[0].neg[k] <= qv[3-k][Q_W-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage in all four lanes.
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [REM_W-1:0] d;
            if (w_en) begin
                d = REM_W'(r_div[j].n) << (DIV_STAGES - 1 - j);
                r_div[j+1].n   <= r_div[j].n;
                r_div[j+1].neg <= r_div[j].neg;
                for (int k = 0; k < 4; k++) begin
                    if (r_div[j].rem[k] >= d) begin
                        r_div[j+1].rem[k] <= r_div[j].rem[k] - d;
                        r_div[j+1].quo[k] <= r_div[j].quo[k]
                                           | (W_W'(1) << (DIV_STAGES - 1 - j));
                    end else begin
                        r_div[j+1].rem[k] <= r_div[j].rem[k];
                        r_div[j+1].quo[k] <= r_div[j].quo[k];
                    end
                end
            end
        end
    end

    // Valid bits of all stages after the CORDIC lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_p3v <= 1'b0;
            r_p4v <= 1'b0;
            r_p5v <= 1'b0;
            r_p6v <= 1'b0;
            for (int k = 0; k <= SQ_STAGES; k++) begin
                r_sqv[k] <= 1'b0;
            end
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p1v    <= w_v_r && w_v_p && w_v_y;
            r_p2v    <= r_p1v;
            r_p3v    <= r_p2v;
            r_p4v    <= r_p3v;
            r_p5v    <= r_p4v;
            r_p6v    <= r_p5v;
            r_sqv[0] <= r_p6v;
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sqv[k+1] <= r_sqv[k];
            end
            r_dv[0] <= r_sqv[SQ_STAGES];
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_out_valid <= r_dv[DIV_STAGES];
        end
    end

    // Saturate, restore signs, force a non-negative scalar part; a zero norm gives the identity.
    always_ff @(posedge i_clk) begin
        logic [3:0][W_W-1:0] sat;
        logic                nz;
        logic                flip_all;
        logic [3:0]          sgn;
        t_div                d;
        if (w_en) begin
            d  = r_div[DIV_STAGES];
            nz = (d.n != '0);
            for (int k = 0; k < 4; k++) begin
                sat[k] = (d.quo[k] > ONE_W) ? ONE_W : d.quo[k];
            end
            flip_all = d.neg[0] && (sat[0] != '0);
            for (int k = 0; k < 4; k++) begin
                sgn[k] = d.neg[k] ^ flip_all;
            end
            if (nz) begin
                r_w <= sat[0];
                r_x <= sgn[1] ? -Q_W'(sat[1]) : Q_W'(sat[1]);
                r_y <= sgn[2] ? -Q_W'(sat[2]) : Q_W'(sat[2]);
                r_z <= sgn[3] ? -Q_W'(sat[3]) : Q_W'(sat[3]);
            end else begin
                r_w <= ONE_W;
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_quat_w = r_w;
    assign o_quat_x = r_x;
    assign o_quat_y = r_y;
    assign o_quat_z = r_z;

endmodule

[hw/rtl/euler_to_quaternion.sv]
// Euler angles (roll, pitch, yaw; Z-Y-X order) to a unit quaternion.
// Request side: drive the three Q3.28 angles and raise push; the request is
// taken on a rising edge where push is high and full is low.
// Result side: while empty is low the oldest quaternion (w as unsigned Q1.30,
// x, y, z as signed Q1.30) sits on the outputs; it is taken on a rising edge
// where pop is high. Results come out in request order, one per request.
// From acceptance to empty falling a request passes the three CORDIC lanes,
// the product stages, a 32-stage square root and a 31-stage divider.
// Throughput: one request per cycle while results are taken, since every
// stage is pipelined.
// When pop stays low the back end freezes behind the held result, the front
// keeps filling a four-entry queue, and full rises once that queue and the
// front holding register are occupied.
// Reset (i_rst_n low, synchronous) empties the queue and all pipeline stages.
`timescale 1ns / 1ps
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int CORDIC_STEPS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic signed [31:0]    i_roll_angle,
    input  logic signed [31:0]    i_pitch_angle,
    input  logic signed [31:0]    i_yaw_angle,
    output logic                  empty,
    input  logic                  pop,
    output logic [W_W-1:0]        o_quat_w,
    output logic signed [Q_W-1:0] o_quat_x,
    output logic signed [Q_W-1:0] o_quat_y,
    output logic signed [Q_W-1:0] o_quat_z
);

    t_queue_stat w_qstat;
    t_class      w_cls_in;
    t_class      w_cls_out;
    logic        w_qpush;
    logic        w_deq;
    logic        w_out_ok;
    logic        w_hold;

    // Front: accept and range-reduce requests.
    e2q_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle),
        .i_qstat(w_qstat), .o_qpush(w_qpush), .o_cls(w_cls_in)
    );

    // Short queue between front and back.
    e2q_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_qpush), .i_data(w_cls_in),
        .i_pop(w_deq), .o_data(w_cls_out), .o_stat(w_qstat)
    );

    // Back: CORDIC, products, normalization and result register.
    e2q_back #(.STEPS(CORDIC_STEPS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cls(w_cls_out), .i_q_empty(w_qstat.empty), .o_deq(w_deq),
        .i_pop(pop), .o_empty(empty),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x),
        .o_quat_y(o_quat_y), .o_quat_z(o_quat_z)
    );

    // Every part lies within unit magnitude.
    assign w_out_ok = (o_quat_w <= ONE_W)
                   && (o_quat_x <= ONE_Q30) && (o_quat_x >= -ONE_Q30)
                   && (o_quat_y <= ONE_Q30) && (o_quat_y >= -ONE_Q30)
                   && (o_quat_z <= ONE_Q30) && (o_quat_z >= -ONE_Q30);

    // A held result with work waiting in the queue.
    assign w_hold = !empty && !pop && !w_qstat.empty;

    // Results stay within unit magnitude.
    `E2Q_ASSERT_NOW(a_out_range, !empty, w_out_ok, "quaternion component out of range")
    // Full is only raised when the queue itself is full.
    `E2Q_ASSERT_NOW(a_full_cause, full, w_qstat.full, "full raised with room in the queue")
    // A request moved from the front lands in the queue.
    `E2Q_ASSERT_NEXT(a_front_lands, w_qpush, !w_qstat.empty, "queue empty after a push")
    // A held result freezes the back end, so the queue does not drain.
    `E2Q_ASSERT_NEXT(a_stall_holds, w_hold, !w_qstat.empty, "queue drained during a stall")

endmodule

[tb/euler_to_quaternion_checker.sv]
`timescale 1ns / 1ps
module euler_to_quaternion_checker
    import e2q_pkg::*;
#(
    parameter int CORDIC_STEPS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic signed [31:0]    i_roll_angle,
    input  logic signed [31:0]    i_pitch_angle,
    input  logic signed [31:0]    i_yaw_angle,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [W_W-1:0]        i_quat_w,
    input  logic signed [Q_W-1:0] i_quat_x,
    input  logic signed [Q_W-1:0] i_quat_y,
    input  logic signed [Q_W-1:0] i_quat_z,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);

    typedef struct packed {
        logic [W_W-1:0]        w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_quat;

    t_quat quat_queue[$];

    // Round half up while dropping s low bits.
    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Sine and cosine of a Q.40 half angle, gain included, in Q.30.
    function automatic void half_sincos(input longint ang, output longint c,
                                        output longint s);
        longint vx;
        longint vy;
        longint nx;
        longint a;
        bit     flip;
        a    = ang;
        vx   = 64'sd1 <<< 39;
        vy   = 0;
        flip = 1'b0;
        // Fold the half angle into the converging range.
        if (a > longint'(HALF_PI_Q40)) begin
            a    = a - longint'(PI_Q40);
            flip = 1'b1;
        end else if (a < -longint'(HALF_PI_Q40)) begin
            a    = a + longint'(PI_Q40);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            if (a >= 0) begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                a  = a - longint'(ATAN_ROM[i]);
            end else begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                a  = a + longint'(ATAN_ROM[i]);
            end
            vx = nx;
        end
        vx = rnd_shift(vx, 10);
        vy = rnd_shift(vy, 10);
        c  = flip ? -vx : vx;
        s  = flip ? -vy : vy;
    endfunction

    // Floor of the square root, bit by bit.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale one part to unit length, saturating at one.
    function automatic longint unit_part(longint v, longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q   = ((mag << 30) + n / 2) / n;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_quat quat_of_angles(logic signed [31:0] r, logic signed [31:0] p,
                                             logic signed [31:0] yw);
        longint cr, sr, cp, sp, cy, sy;
        longint crcp, srsp, crsp, srcp;
        longint q[4];
        longint unsigned sum;
        longint unsigned n;
        t_quat res;
        half_sincos(longint'(r) * 2048, cr, sr);
        half_sincos(longint'(p) * 2048, cp, sp);
        half_sincos(longint'(yw) * 2048, cy, sy);
        crcp = rnd_shift(cr * cp, 30);
        srsp = rnd_shift(sr * sp, 30);
        crsp = rnd_shift(cr * sp, 30);
        srcp = rnd_shift(sr * cp, 30);
        q[0] = rnd_shift(crcp * cy + srsp * sy, 30);
        q[1] = rnd_shift(srcp * cy - crsp * sy, 30);
        q[2] = rnd_shift(crsp * cy + srcp * sy, 30);
        q[3] = rnd_shift(crcp * sy - srsp * cy, 30);
        sum = 0;
        for (int k = 0; k < 4; k++) sum = sum + longint'(q[k] * q[k]);
        n = root_floor(sum);
        if (n == 0) begin
            q[0] = 64'sd1 <<< 30;
            q[1] = 0;
            q[2] = 0;
            q[3] = 0;
        end else begin
            for (int k = 0; k < 4; k++) q[k] = unit_part(q[k], n);
            // Keep the scalar part in the upper hemisphere.
            if (q[0] < 0) for (int k = 0; k < 4; k++) q[k] = -q[k];
        end
        res.w = q[0][W_W-1:0];
        res.x = q[1][Q_W-1:0];
        res.y = q[2][Q_W-1:0];
        res.z = q[3][Q_W-1:0];
        return res;
    endfunction

    // Predict on each accepted request and compare each accepted result.
    always @(posedge i_clk) begin
        t_quat want;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (push && !full)
                quat_queue.insert(quat_queue.size(),
                                  quat_of_angles(i_roll_angle, i_pitch_angle,
                                                 i_yaw_angle));
            if (pop && !empty) begin
                o_results <= o_results + 1;
                if (quat_queue.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result with no request waiting", $realtime);
                    o_errors <= o_errors + 1;
                end else begin
                    want = quat_queue.pop_front();
                    if (want.w !== i_quat_w || want.x !== i_quat_x ||
                        want.y !== i_quat_y || want.z !== i_quat_z) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch exp w=%0d x=%0d y=%0d z=%0d",
                                     $realtime, want.w, want.x, want.y, want.z,
                                     " got w=%0d x=%0d y=%0d z=%0d",
                                     i_quat_w, i_quat_x, i_quat_y, i_quat_z);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= quat_queue.size();
    end

endmodule

[tb/euler_to_quaternion_tb.sv]
`timescale 1ns / 1ps
module euler_to_quaternion_tb;
    import e2q_pkg::*;

    localparam int LATENCY = 30 + 75;
    localparam logic signed [31:0] PI_Q28 = 32'sd843314857;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic signed [31:0]    i_roll_angle = '0;
    logic signed [31:0]    i_pitch_angle = '0;
    logic signed [31:0]    i_yaw_angle = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [W_W-1:0]        o_quat_w;
    logic signed [Q_W-1:0] o_quat_x;
    logic signed [Q_W-1:0] o_quat_y;
    logic signed [Q_W-1:0] o_quat_z;
    int                    fail_count;
    int                    pending;
    int                    result_count;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    euler_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle), .empty(empty), .pop(pop),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z)
    );

    euler_to_quaternion_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle), .empty(empty), .pop(pop),
        .i_quat_w(o_quat_w), .i_quat_x(o_quat_x), .i_quat_y(o_quat_y),
        .i_quat_z(o_quat_z), .o_errors(fail_count), .o_pending(pending),
        .o_results(result_count)
    );

    // The result side stalls at random.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one angle request and hold it until it is taken.
    task automatic send_angles(logic signed [31:0] r, logic signed [31:0] p,
                               logic signed [31:0] yw);
        bit held;
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        push          <= 1'b1;
        i_roll_angle  <= r;
        i_pitch_angle <= p;
        i_yaw_angle   <= yw;
        forever begin
            @(negedge i_clk);
            held = full;
            @(posedge i_clk);
            if (!held) break;
        end
    endtask

    // Mostly angles within one turn, sometimes any word at all.
    function automatic logic signed [31:0] pick_angle();
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom_range(2 * PI_Q28)) - PI_Q28;
    endfunction

    // Hold off new requests until every result has drained.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        logic signed [31:0] corner[10];
        corner = '{32'sd0, 32'sh7fffffff, 32'sh80000000, PI_Q28, -PI_Q28,
                   PI_Q28 - 1, PI_Q28 + 1, -PI_Q28 - 1, PI_Q28 / 2, 32'sd1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, half angles past a quarter turn, and near-zero scalar parts.
        for (int i = 0; i < 10; i++) send_angles(corner[i], 0, 0);
        for (int i = 0; i < 6; i++) send_angles(0, corner[i], corner[9 - i]);
        send_angles(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_angles(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_angles(PI_Q28, PI_Q28, PI_Q28);
        send_angles(-PI_Q28, PI_Q28 / 2, PI_Q28);
        send_angles(0, 0, PI_Q28);
        send_angles(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);

        // Three idling phases, draining between them.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
            rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 30 : 0;
            drain();
            for (int n = 0; n < 177; n++) send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        drain();

        $display("Ran %0d requests: corner angles, folded half angles and random triples,",
                 result_count);
        $display("under sender and receiver stalls in both proportions and at full rate.");
        if (fail_count == 0) begin
            $display("euler_to_quaternion_tb: done, clean");
        end else begin
            $display("euler_to_quaternion_tb: done, errors");
        end
        $finish;
    end

    // Guard against a hang.
    initial begin
        #20000000;
        $display("euler_to_quaternion_tb: done, errors");
        $finish;
    end

endmodule
